// ----- rtl/packbits_style_rle_encoder_unit_defines.svh -----
// ============================================================================
// PackBits RLE encoder assertion macros
// Shared assertion shorthands; the using module provides aclk and aresetn.
// ============================================================================
`ifndef PACKBITS_STYLE_RLE_ENCODER_UNIT_DEFINES_SVH
`define PACKBITS_STYLE_RLE_ENCODER_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PBRLE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// trigger in one cycle implies the consequence in the next
`define PBRLE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/pbrle_pkg.sv -----
// ============================================================================
// pbrle_pkg
// Shared constants and controller/datapath interface types.
// ============================================================================
package pbrle_pkg;

    localparam int unsigned MAX_SPAN_DEF   = 128;
    localparam int unsigned WORD_BYTES_DEF = 8;
    localparam int unsigned RUN_MIN        = 3;
    localparam int unsigned OUT_WORD_W     = 64;
    localparam int unsigned COUNT_W        = 4;

    // source of a byte appended to the literal buffer
    localparam logic LIT_SRC_LA0 = 1'b0;
    localparam logic LIT_SRC_LA1 = 1'b1;

    // what the packer takes this cycle
    typedef enum logic [2:0] {
        PUT_NONE,
        PUT_LIT_HDR,
        PUT_LIT_BODY,
        PUT_RUN_HDR,
        PUT_RUN_VAL
    } put_sel_t;

    typedef struct packed {
        logic     cap_in;
        logic     run_inc;
        logic     run_start;
        logic     run_clr;
        logic     la_push;
        logic     la_clr;
        logic     lit_add;
        logic     lit_src;
        logic     lit_clr;
        logic     idx_clr;
        logic     idx_inc;
        put_sel_t put_sel;
        logic     emit_last;
    } pbrle_cmd_t;

    typedef struct packed {
        logic       fin;
        logic       put_ready;
        logic       out_free;
        logic       run_open;
        logic       run_match;
        logic       run_full;
        logic [1:0] la_cnt;
        logic       triple;
        logic       lit_open;
        logic       lit_fill_next;
        logic       lit_last;
        logic       pack_open;
    } pbrle_stat_t;

endpackage

// ----- rtl/pbrle_dp.sv -----
// ============================================================================
// pbrle_dp
// Datapath: lookahead, run tracker, literal buffer, byte packer, output reg.
// ============================================================================
`include "packbits_style_rle_encoder_unit_defines.svh"

module pbrle_dp #(
    parameter int unsigned MAX_SPAN   = pbrle_pkg::MAX_SPAN_DEF,
    parameter int unsigned WORD_BYTES = pbrle_pkg::WORD_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [7:0]                        in_byte,
    input  logic                              in_last,
    input  pbrle_pkg::pbrle_cmd_t             cmd,
    output pbrle_pkg::pbrle_stat_t            stat,
    output logic [pbrle_pkg::OUT_WORD_W-1:0]  out_word,
    output logic [pbrle_pkg::COUNT_W-1:0]     out_count,
    output logic                              out_end,
    output logic                              out_valid,
    input  logic                              out_ready
);
    import pbrle_pkg::*;

    localparam int unsigned AW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int unsigned LW = $clog2(MAX_SPAN + 1);
    localparam int unsigned FW = $clog2(WORD_BYTES + 1);
    localparam int unsigned PW = WORD_BYTES * 8;

    logic [7:0]    byte_reg;
    logic          fin_reg;
    logic [7:0]    run_val_reg;
    logic [LW-1:0] run_len_reg;
    logic [7:0]    la0_reg, la1_reg;
    logic [1:0]    la_cnt_reg;
    logic [LW-1:0] lit_len_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0]    rd_reg;
    logic [7:0]    lit_mem [MAX_SPAN];
    logic [PW-1:0] pack_reg, pack_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [OUT_WORD_W-1:0] out_word_reg;
    logic [COUNT_W-1:0]    out_cnt_reg;
    logic          out_end_reg, out_valid_reg;

    logic          out_free, put_ready, put_en, pack_full, lit_last;
    logic [7:0]    put_byte, lit_in;
    logic [AW-1:0] rd_addr;
    logic          out_cnt_ok;

    // status toward the controller
    assign out_free  = !out_valid_reg || out_ready;
    assign pack_full = (fill_reg == FW'(WORD_BYTES));
    assign put_ready = !pack_full || out_free;
    assign put_en    = (cmd.put_sel != PUT_NONE) && put_ready;
    assign lit_last  = ((LW'(idx_reg) + LW'(1)) == lit_len_reg);

    always_comb begin
        stat.fin           = fin_reg;
        stat.put_ready     = put_ready;
        stat.out_free      = out_free;
        stat.run_open      = (run_len_reg != '0);
        stat.run_match     = (byte_reg == run_val_reg) && (run_len_reg < LW'(MAX_SPAN));
        stat.run_full      = (run_len_reg >= LW'(MAX_SPAN));
        stat.la_cnt        = la_cnt_reg;
        stat.triple        = (la0_reg == la1_reg) && (la1_reg == byte_reg);
        stat.lit_open      = (lit_len_reg != '0);
        stat.lit_fill_next = (lit_len_reg == LW'(MAX_SPAN - 1));
        stat.lit_last      = lit_last;
        stat.pack_open     = (fill_reg != '0);
    end

    // byte offered to the packer
    always_comb begin
        case (cmd.put_sel)
            PUT_LIT_HDR:  put_byte = 8'(lit_len_reg - LW'(1));
            PUT_LIT_BODY: put_byte = rd_reg;
            PUT_RUN_HDR:  put_byte = 8'(9'd257 - 9'(run_len_reg));
            PUT_RUN_VAL:  put_byte = run_val_reg;
            default:      put_byte = 8'd0;
        endcase
    end

    // packer next state: a full word leaves when another byte arrives or on emit_last
    always_comb begin
        pack_next = pack_reg;
        fill_next = fill_reg;
        if (cmd.emit_last) begin
            pack_next = '0;
            fill_next = '0;
        end else if (put_en) begin
            if (pack_full) begin
                pack_next = PW'(put_byte);
                fill_next = FW'(1);
            end else begin
                for (int i = 0; i < WORD_BYTES; i++) begin
                    if (fill_reg == FW'(i)) pack_next[i*8 +: 8] = put_byte;
                end
                fill_next = fill_reg + FW'(1);
            end
        end
    end

    // literal buffer read address, one entry ahead while the body streams out
    always_comb begin
        if (cmd.put_sel == PUT_LIT_BODY && put_ready && !lit_last) rd_addr = idx_reg + AW'(1);
        else if (cmd.put_sel == PUT_LIT_BODY)                    rd_addr = idx_reg;
        else                                                     rd_addr = '0;
    end

    assign lit_in = (cmd.lit_src == LIT_SRC_LA1) ? la1_reg : la0_reg;

    // literal buffer memory
    always_ff @(posedge aclk) begin
        if (cmd.lit_add) lit_mem[lit_len_reg[AW-1:0]] <= lit_in;
        rd_reg <= lit_mem[rd_addr];
    end

    // input capture and lookahead bytes (payload)
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            byte_reg <= in_byte;
            fin_reg  <= in_last;
        end
        if (cmd.la_push) begin
            case (la_cnt_reg)
                2'd0:    la0_reg <= byte_reg;
                2'd1:    la1_reg <= byte_reg;
                default: begin
                    la0_reg <= la1_reg;
                    la1_reg <= byte_reg;
                end
            endcase
        end
        if (cmd.run_start) run_val_reg <= la0_reg;
        if (cmd.idx_clr)      idx_reg <= '0;
        else if (cmd.idx_inc) idx_reg <= idx_reg + AW'(1);
    end

    // control counters, packer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg   <= '0;
            la_cnt_reg    <= '0;
            lit_len_reg   <= '0;
            pack_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.run_start)    run_len_reg <= LW'(RUN_MIN);
            else if (cmd.run_inc) run_len_reg <= run_len_reg + LW'(1);
            else if (cmd.run_clr) run_len_reg <= '0;

            if (cmd.la_clr) la_cnt_reg <= '0;
            else if (cmd.la_push && la_cnt_reg != 2'd2) la_cnt_reg <= la_cnt_reg + 2'd1;

            if (cmd.lit_clr)      lit_len_reg <= '0;
            else if (cmd.lit_add) lit_len_reg <= lit_len_reg + LW'(1);

            pack_reg <= pack_next;
            fill_reg <= fill_next;

            if (cmd.emit_last || (put_en && pack_full)) out_valid_reg <= 1'b1;
            else if (out_ready)                         out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_last || (put_en && pack_full)) begin
            out_word_reg <= OUT_WORD_W'(pack_reg);
            out_cnt_reg  <= COUNT_W'(fill_reg);
            out_end_reg  <= cmd.emit_last && fin_reg;
        end
    end

    assign out_word  = out_word_reg;
    assign out_count = out_cnt_reg;
    assign out_end   = out_end_reg;
    assign out_valid = out_valid_reg;

    // byte count of a presented word stays within one word
    assign out_cnt_ok = (out_cnt_reg != '0) && (out_cnt_reg <= COUNT_W'(WORD_BYTES));

    `PBRLE_ASSERT(a_lit_len_range, lit_len_reg <= LW'(MAX_SPAN), "literal length over span")
    `PBRLE_ASSERT(a_run_len_range, run_len_reg == '0 || run_len_reg >= LW'(RUN_MIN), "short run")
    `PBRLE_ASSERT(a_out_count, !out_valid_reg || out_cnt_ok, "bad byte count")
    `PBRLE_ASSERT_NEXT(a_emit_valid, cmd.emit_last, out_valid_reg, "final word not presented")

endmodule

// ----- rtl/pbrle_ctrl.sv -----
// ============================================================================
// pbrle_ctrl
// Sequencer: walks one input byte through run, lookahead, tail and flushes.
// ============================================================================
module pbrle_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pbrle_pkg::pbrle_stat_t stat,
    output pbrle_pkg::pbrle_cmd_t  cmd
);
    import pbrle_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RUN, ST_LA, ST_CHK, ST_FIN0, ST_FIN1, ST_FINL, ST_FINR,
        ST_LHDR, ST_LBODY, ST_RHDR, ST_RVAL, ST_DONE
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic   taken_reg, taken_next;

    // next state and datapath commands
    always_comb begin
        cmd        = '0;
        cmd.put_sel = PUT_NONE;
        state_next = state_reg;
        ret_next   = ret_reg;
        taken_next = taken_reg;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.cap_in = 1'b1;
                    state_next = ST_RUN;
                end
            end
            // extend or close an open run
            ST_RUN: begin
                taken_next = 1'b0;
                state_next = ST_LA;
                if (stat.run_open) begin
                    if (stat.run_match) begin
                        cmd.run_inc = 1'b1;
                        taken_next  = 1'b1;
                        state_next  = ST_CHK;
                    end else begin
                        ret_next   = ST_LA;
                        state_next = ST_RHDR;
                    end
                end
            end
            // lookahead window decision
            ST_LA: begin
                state_next = ST_CHK;
                if (!taken_reg) begin
                    if (stat.la_cnt == 2'd2) begin
                        if (stat.triple) begin
                            cmd.run_start = 1'b1;
                            cmd.la_clr    = 1'b1;
                            if (stat.lit_open) begin
                                ret_next   = ST_CHK;
                                state_next = ST_LHDR;
                            end
                        end else begin
                            cmd.lit_add = 1'b1;
                            cmd.lit_src = LIT_SRC_LA0;
                            cmd.la_push = 1'b1;
                            if (stat.lit_fill_next) begin
                                ret_next   = ST_CHK;
                                state_next = ST_LHDR;
                            end
                        end
                    end else begin
                        cmd.la_push = 1'b1;
                    end
                end
            end
            // a run that reached full span goes out at once
            ST_CHK: begin
                state_next = ST_FIN0;
                if (stat.run_full) begin
                    ret_next   = ST_FIN0;
                    state_next = ST_RHDR;
                end
            end
            // packet tail: leftover lookahead bytes join the literal
            ST_FIN0: begin
                state_next = ST_FIN1;
                if (stat.fin && stat.la_cnt != 2'd0) begin
                    cmd.lit_add = 1'b1;
                    cmd.lit_src = LIT_SRC_LA0;
                    if (stat.lit_fill_next) begin
                        ret_next   = ST_FIN1;
                        state_next = ST_LHDR;
                    end
                end
            end
            ST_FIN1: begin
                state_next = ST_FINL;
                if (stat.fin && stat.la_cnt == 2'd2) begin
                    cmd.lit_add = 1'b1;
                    cmd.lit_src = LIT_SRC_LA1;
                    if (stat.lit_fill_next) begin
                        ret_next   = ST_FINL;
                        state_next = ST_LHDR;
                    end
                end
            end
            ST_FINL: begin
                state_next = ST_FINR;
                if (stat.fin) begin
                    cmd.la_clr = 1'b1;
                    if (stat.lit_open) begin
                        ret_next   = ST_FINR;
                        state_next = ST_LHDR;
                    end
                end
            end
            ST_FINR: begin
                state_next = ST_DONE;
                if (stat.fin && stat.run_open) begin
                    ret_next   = ST_DONE;
                    state_next = ST_RHDR;
                end
            end
            // literal flush: header, then one buffered byte per cycle while the packer is ready
            ST_LHDR: begin
                cmd.put_sel = PUT_LIT_HDR;
                if (stat.put_ready) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_LBODY;
                end
            end
            ST_LBODY: begin
                cmd.put_sel = PUT_LIT_BODY;
                if (stat.put_ready) begin
                    cmd.idx_inc = 1'b1;
                    if (stat.lit_last) begin
                        cmd.lit_clr = 1'b1;
                        state_next  = ret_reg;
                    end
                end
            end
            // run flush: header and value
            ST_RHDR: begin
                cmd.put_sel = PUT_RUN_HDR;
                if (stat.put_ready) state_next = ST_RVAL;
            end
            ST_RVAL: begin
                cmd.put_sel = PUT_RUN_VAL;
                if (stat.put_ready) begin
                    cmd.run_clr = 1'b1;
                    state_next  = ret_reg;
                end
            end
            // last (possibly partial) word of this byte's output
            ST_DONE: begin
                if (!stat.pack_open) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            taken_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            taken_reg <= taken_next;
        end
    end

endmodule

// ----- rtl/packbits_style_rle_encoder_unit.sv -----
// ============================================================================
// packbits_style_rle_encoder_unit
// PackBits-style run-length encoder, one raw byte in, packed words out.
// ============================================================================
// Usage:
//   s_ channel: one raw byte per beat, s_tlast on the last byte of a packet.
//   m_ channel: compressed bytes packed WORD_BYTES to a word, first byte in
//   the low lane; tdata carries the word and its valid byte count, m_tlast
//   marks the final word of the packet.
//   Each byte runs through a sequencer: run, lookahead, check, tail and
//   done states lie between one accept and the next; flushing a literal
//   adds its header and each buffered byte, flushing a run adds its header
//   and value. The literal buffer is read one entry per cycle while the
//   packer is ready, which sets the flush length.
//   A full word moves to the output register when the next byte is packed
//   or when the byte's output closes; the last word of a packet leaves
//   from the done state, after the final byte's flushes.
//   A stalled receiver holds the packer once it is full; input is taken
//   again once the current byte's output is all in the output register.
//   Reset clears the run, lookahead and literal counts, the packer and
//   the output valid flag; the literal buffer needs no clearing pass.
// ============================================================================
module packbits_style_rle_encoder_unit #(
    parameter int unsigned MAX_SPAN   = pbrle_pkg::MAX_SPAN_DEF,
    parameter int unsigned WORD_BYTES = pbrle_pkg::WORD_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] out_word, [67:64] byte_count, rest zero
    output logic        m_tlast    // packet_end
);
    import pbrle_pkg::*;

    pbrle_cmd_t            cmd;
    pbrle_stat_t           stat;
    logic [OUT_WORD_W-1:0] out_word;
    logic [COUNT_W-1:0]    out_count;

    pbrle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pbrle_dp #(
        .MAX_SPAN   (MAX_SPAN),
        .WORD_BYTES (WORD_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_word),
        .out_count (out_count),
        .out_end   (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {4'd0, out_count, out_word};

endmodule
